// ===== src/sha_pkg.sv =====
// sha-256 shared package: round constants, initial hash, controller commands
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_FINISH  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam int unsigned LEN_POS  = 56;

  // block buffer write source
  typedef enum logic [1:0] {
    WSRC_DATA = 2'd0,
    WSRC_PAD  = 2'd1,
    WSRC_ZERO = 2'd2,
    WSRC_LEN  = 2'd3
  } wsrc_t;

  typedef struct packed {
    logic        buf_we;
    wsrc_t       wsrc;
    logic [5:0]  waddr;
    logic        count_inc;
    logic        init;
    logic        comp_start;
    logic        comp_round;
    logic [5:0]  round;
    logic        comp_done;
    logic        emit_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } dp_stat_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_datapath.sv =====
// sha-256 datapath: block buffer, message schedule, round logic, chaining words
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  rd_idx,
  output dp_stat_t    stat,
  output logic [31:0] rd_word
);

  // block buffer held as sixteen big-endian words
  logic [31:0] blk_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] count_r;
  logic [7:0]  wdata;
  logic [63:0] bits;
  logic [31:0] w_cur, w_new, s0, s1, t1, t2, big0, big1, ch, mj;

  assign bits = {count_r[60:0], 3'b000};
  assign stat.pos = count_r[5:0];

  always_comb begin
    case (cmd.wsrc)
      WSRC_DATA: wdata = data_byte;
      WSRC_PAD:  wdata = PAD_BYTE;
      WSRC_ZERO: wdata = 8'h00;
      default:   wdata = bits[8 * (7 - cmd.waddr[2:0]) +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_we) blk_r[cmd.waddr[5:2]][8 * (3 - cmd.waddr[1:0]) +: 8] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) count_r <= '0;
    else if (cmd.count_inc) count_r <= count_r + 64'd1;
  end

  assign s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = s1 + w_r[9] + s0 + w_r[0];
  assign w_cur = w_r[0];

  assign big1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1 = v_r[7] + big1 + ch + ROUND_K[cmd.round] + w_cur;
  assign big0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2 = big0 + mj;

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      for (int i = 0; i < 16; i++) w_r[i] <= blk_r[i];
    end else if (cmd.comp_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else if (cmd.comp_done) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign rd_word = cmd.emit_zero ? 32'h0 : h_r[rd_idx];

endmodule

// ===== src/sha_ctrl.sv =====
// sha-256 controller: item decode, padding sweep, round sequencing, digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] word_index,
  output logic       last_word,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_DONE  = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;
  logic       last_r, last_nxt;   // current compression ends the message
  logic       pad_r, pad_nxt;     // finish whose length block is still to be built
  logic       zero_r, zero_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_valid = (state_r == S_EMIT);
  assign word_index = idx_r;
  assign last_word = (idx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    last_nxt = last_r;
    pad_nxt = pad_r;
    zero_nxt = zero_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.wsrc = WSRC_DATA;
    cmd.waddr = stat.pos;
    cmd.round = cnt_r;
    cmd.emit_zero = zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_RESTART: begin
              cmd.init = 1'b1;
              fin_nxt = 1'b0;
            end
            KIND_BYTE: begin
              if (!fin_r) begin
                cmd.buf_we = 1'b1;
                cmd.count_inc = 1'b1;
                if (stat.pos == 6'd63) begin
                  last_nxt = 1'b0;
                  state_nxt = S_START;
                end
              end
            end
            KIND_FINISH: begin
              idx_nxt = '0;
              if (fin_r) begin
                zero_nxt = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                zero_nxt = 1'b0;
                cmd.buf_we = 1'b1;
                cmd.wsrc = WSRC_PAD;
                cnt_nxt = stat.pos + 6'd1;
                last_nxt = (stat.pos < LEN_POS[5:0]);
                pad_nxt = !(stat.pos < LEN_POS[5:0]);
                state_nxt = (stat.pos == 6'd63) ? S_PAD : S_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        // pad byte sat in the last slot: compress, then a fresh block
        last_nxt = 1'b0;
        state_nxt = S_START;
      end
      S_FILL: begin
        cmd.buf_we = 1'b1;
        cmd.waddr = cnt_r;
        cmd.wsrc = (cnt_r >= LEN_POS[5:0] && last_r) ? WSRC_LEN : WSRC_ZERO;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_START;
      end
      S_START: begin
        cmd.comp_start = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.comp_round = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.comp_done = 1'b1;
        if (last_r) begin
          fin_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else if (pad_r) begin
          pad_nxt = 1'b0;
          last_nxt = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      last_r <= 1'b0;
      pad_r <= 1'b0;
      cnt_r <= '0;
      zero_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      last_r <= last_nxt;
      pad_r <= pad_nxt;
      zero_r <= zero_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== src/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level: controller and datapath
// depends on sha_pkg, sha_ctrl, sha_datapath
`timescale 1ns / 1ps
// usage
//   input channel in_valid / in_stall carries in_kind and in_data_byte
//   kind byte appends a message byte, finish emits the digest, restart
//   reloads the initial hash; kind three is dropped
//   output channel out_valid / out_stall carries eight items per finish:
//   out_digest_word, out_word_index 0..7 and out_last_word on the eighth
// timing
//   a byte is taken while idle; the byte that fills a block starts a compression,
//   done by the single round unit doing one of 64 rounds per cycle
//   finish runs the pad sweep and compression (a second block when the pad
//   byte lands at offset 56 or later), then the eight digest words go out,
//   each advancing only while out_stall is low
//   in_stall is high while a block is padded or compressed or the digest
//   is sent
// reset
//   synchronous rst_n loads the initial hash, clears the byte count and
//   the finished flag; a stalled output word holds until taken
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (out_word_index),
    .last_word  (out_last_word),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_data_byte),
    .rd_idx    (out_word_index),
    .stat      (stat),
    .rd_word   (out_digest_word)
  );

  a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word && !out_stall |=> !out_valid)
    else $error("output continues past last word");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
    out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest word index skipped");

endmodule

// ===== bench/sha256_digest_checker.sv =====
// digest checker for the sha-256 stream hasher bench: tracks accepted items,
// computes the expected digest words and compares them with the output items
// depends on sha_pkg for the round constants, initial hash and kind codes
`timescale 1ns / 1ps
module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_queue[$];

  logic [31:0] chain[8];
  logic [63:0] msg_bytes;
  logic [7:0]  block[64];
  bit          done_flag;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
    for (int i = 0; i < 64; i++) block[i] = 8'h00;
    msg_bytes = '0;
    done_flag = 0;
  endtask

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    for (int i = 0; i < 16; i++)
      w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
           + ROUND_K[i] + w[i];
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic pad_and_close();
    logic [63:0] bits;
    int pos;
    bits = msg_bytes << 3;
    pos = int'(msg_bytes[5:0]);
    block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) block[i] = 8'h00;
      compress();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) block[i] = 8'h00;
    for (int i = 0; i < 8; i++) block[56+i] = bits[63-8*i -: 8];
    compress();
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [7:0] data);
    digest_word_t e;
    int pos;
    if (kind == KIND_RESTART) begin
      clear_hash();
    end else if (kind == KIND_BYTE) begin
      if (!done_flag) begin
        pos = int'(msg_bytes[5:0]);
        block[pos] = data;
        msg_bytes++;
        if (pos == 63) compress();
      end
    end else if (kind == KIND_FINISH) begin
      if (!done_flag) pad_and_close();
      for (int i = 0; i < 8; i++) begin
        e.word = done_flag ? 32'h0 : chain[i];
        e.index = i[2:0];
        e.last = (i == 7);
        digest_queue.push_back(e);
      end
      done_flag = 1;
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    if (fail_count < 10)
      $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_hash();
  end

  assign words_pending = digest_queue.size();

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst_n) begin
      clear_hash();
      digest_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          report("unexpected digest word", 32'h0, out_digest_word);
        end else begin
          e = digest_queue.pop_front();
          if (out_digest_word !== e.word) report("digest_word", e.word, out_digest_word);
          if (out_word_index !== e.index)
            report("word_index", 32'(e.index), 32'(out_word_index));
          if (out_last_word !== e.last)
            report("last_word", 32'(e.last), 32'(out_last_word));
        end
      end
      if (in_valid && !in_stall) predict_item(in_kind, in_data_byte);
    end
  end

endmodule

// ===== bench/sha256_stream_hasher_test.sv =====
// top of the sha-256 stream hasher bench: clock, reset, item stimulus and
// output stall, with the verdict taken from the digest checker
// depends on sha_pkg, sha256_stream_hasher and sha256_digest_checker
`timescale 1ns / 1ps
module sha256_stream_hasher_test;
  import sha_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          words_pending;
  bit          hold_req;
  int          item_count;

  localparam int LONG_HOLD = 400;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  sha256_stream_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  sha256_digest_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // idle gap, then offer one item and wait for it to be taken
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(KIND_BYTE, 8'($urandom));
    send_item(KIND_FINISH, 8'($urandom));
  endtask

  // output side stall
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        gap = pick_gap();
        out_stall <= (gap > 0);
        if (gap > 1) repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int len;
    int r;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_BYTE;
    in_data_byte = 8'h00;
    hold_req = 0;
    item_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty message, repeated finish, byte after finish, unused kind
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_FINISH, 8'hff);
    send_item(KIND_BYTE, 8'hff);
    send_item(KIND_UNUSED, 8'h5a);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_BYTE, 8'h61);
    send_item(KIND_BYTE, 8'h62);
    send_item(KIND_BYTE, 8'h63);
    send_item(KIND_UNUSED, 8'hff);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_RESTART, 8'hff);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hff);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_RESTART, 8'h00);

    hold_req = 1;
    item_count = 0;
    while (item_count < 210) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
      r = $urandom_range(0, 99);
      if (r < 15) send_item(KIND_FINISH, 8'($urandom));
      else if (r < 25) send_item(KIND_BYTE, 8'($urandom));
      else if (r < 32) send_item(KIND_UNUSED, 8'($urandom));
      send_item(KIND_RESTART, 8'($urandom));
      // occasionally a message broken off by a restart
      if ($urandom_range(0, 3) == 0) begin
        for (int i = $urandom_range(1, 20); i > 0; i--) send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_RESTART, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (words_pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
